@@ src/stte_pkg.sv @@
// ----------------------------------------------------------------------------
// stte_pkg
// Shared types and constants for the session table with idle timeout.
// ----------------------------------------------------------------------------
package stte_pkg;

   // field widths
   localparam int OP_W    = 2;
   localparam int NODE_W  = 32;
   localparam int ROOM_W  = 16;
   localparam int FLAGS_W = 8;
   localparam int TIME_W  = 32;
   localparam int EVENT_W = 3;
   localparam int SLOT_W  = 3;

   // stream data widths, padded to whole bytes
   localparam int REQ_BITS   = NODE_W + ROOM_W + FLAGS_W + TIME_W;
   localparam int REQ_DATA_W = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_BITS   = SLOT_W + NODE_W + ROOM_W + FLAGS_W;
   localparam int RSP_DATA_W = ((RSP_BITS + 7) / 8) * 8;

   // idle timeout after reset, in seconds
   localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd3600;

   // opcodes on the request side
   localparam logic [OP_W-1:0] OP_ACCESS   = 2'd0;
   localparam logic [OP_W-1:0] OP_SET_ROOM = 2'd1;
   localparam logic [OP_W-1:0] OP_QUIT     = 2'd2;
   localparam logic [OP_W-1:0] OP_UNUSED   = 2'd3;

   // result event codes
   typedef enum logic [EVENT_W-1:0] {
      EV_EXPIRED   = 3'd0,
      EV_EVICTED   = 3'd1,
      EV_QUIT      = 3'd2,
      EV_FOUND     = 3'd3,
      EV_CREATED   = 3'd4,
      EV_NOT_FOUND = 3'd5
   } event_type;

   // command kind after classification
   typedef enum logic [1:0] {
      KIND_ACCESS,
      KIND_SET_ROOM,
      KIND_QUIT,
      KIND_NONE
   } kind_type;

   // command passed from the front to the engine
   typedef struct packed {
      kind_type            kind;
      logic [NODE_W-1:0]   node_id;
      logic [ROOM_W-1:0]   room;
      logic [FLAGS_W-1:0]  flags_in;
      logic [TIME_W-1:0]   now;
   } cmd_type;

   // one result item
   typedef struct packed {
      event_type           event_res;
      logic [SLOT_W-1:0]   slot;
      logic [NODE_W-1:0]   node_out;
      logic [ROOM_W-1:0]   room_out;
      logic [FLAGS_W-1:0]  flags_out;
      logic                last_of_run;
   } rsp_type;

endpackage

@@ src/stte_front.sv @@
// ----------------------------------------------------------------------------
// stte_front
// Accepts request items, classifies the opcode and queues the command.
// ----------------------------------------------------------------------------
module stte_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // node_id[31:0], room[47:32], flags_in[55:48], now[87:56]
   input  logic [stte_pkg::REQ_DATA_W-1:0]     req_tdata,
   // opcode[1:0]
   input  logic [stte_pkg::OP_W-1:0]           req_tuser,
   output logic                                q_valid,
   input  logic                                q_pop,
   output stte_pkg::cmd_type                   q_head
);
   import stte_pkg::*;

   localparam int DEPTH = 2;

   cmd_type     cmd;
   cmd_type     queue_ff [DEPTH];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        push;

   // classify the opcode
   always_comb begin
      unique case (req_tuser)
         OP_ACCESS:   cmd.kind = KIND_ACCESS;
         OP_SET_ROOM: cmd.kind = KIND_SET_ROOM;
         OP_QUIT:     cmd.kind = KIND_QUIT;
         OP_UNUSED:   cmd.kind = KIND_NONE;
         default:     cmd.kind = KIND_NONE;
      endcase
      cmd.node_id  = req_tdata[0 +: NODE_W];
      cmd.room     = req_tdata[NODE_W +: ROOM_W];
      cmd.flags_in = req_tdata[NODE_W+ROOM_W +: FLAGS_W];
      cmd.now      = req_tdata[NODE_W+ROOM_W+FLAGS_W +: TIME_W];
   end

   // queue control
   assign req_tready = (count_ff != 2'(DEPTH));
   assign push       = req_tvalid && req_tready;
   assign q_valid    = (count_ff != 2'd0);
   assign q_head     = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push  ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= cmd;
      end
   end

endmodule

@@ src/stte_engine.sv @@
// ----------------------------------------------------------------------------
// stte_engine
// Holds the session table, runs commands one slot a cycle unless stalled.
// ----------------------------------------------------------------------------
module stte_engine #(
   parameter int SLOTS = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [stte_pkg::TIME_W-1:0]   timeout,
   input  logic                          q_valid,
   output logic                          q_pop,
   input  stte_pkg::cmd_type             q_head,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output stte_pkg::rsp_type             rsp_item
);
   import stte_pkg::*;

   localparam int IDX_W = $clog2(SLOTS);
   localparam logic [IDX_W:0] LAST_IDX = (IDX_W+1)'(SLOTS - 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXPIRE,
      S_LOOKUP,
      S_MIN,
      S_EVICT,
      S_CREATE
   } state_type;

   state_type            state_ff, state_in;
   logic [IDX_W:0]       cnt_ff, cnt_in;
   logic [IDX_W-1:0]     tgt_ff, tgt_in;
   cmd_type              cmd_ff, cmd_in;
   logic [SLOTS-1:0]     valid_ff, valid_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   // table storage
   logic [NODE_W-1:0]    node_ff  [SLOTS];
   logic [ROOM_W-1:0]    room_ff  [SLOTS];
   logic [FLAGS_W-1:0]   flags_ff [SLOTS];
   logic [TIME_W-1:0]    time_ff  [SLOTS];

   logic [IDX_W-1:0]     idx;
   logic [TIME_W-1:0]    age;
   logic                 expire_hit;
   logic                 older;
   logic [SLOTS-1:0]     match;
   logic                 hit_any, free_any;
   logic [IDX_W-1:0]     hit_idx, free_idx;
   logic [IDX_W-1:0]     rd_idx;
   logic                 out_free;
   logic                 emit;
   logic                 wr_all, wr_time, wr_room;
   logic [IDX_W-1:0]     wr_idx;

   // low bits of a table index as reported on the result
   function automatic logic [SLOT_W-1:0] slot_of(input logic [IDX_W-1:0] i);
      logic [IDX_W+SLOT_W-1:0] wide;
      wide = {{SLOT_W{1'b0}}, i};
      return wide[SLOT_W-1:0];
   endfunction

   assign idx      = cnt_ff[IDX_W-1:0];
   assign out_free = !rsp_valid_ff || rsp_ready;

   // expiry test for the slot under the scan
   assign age        = cmd_ff.now - time_ff[idx];
   assign expire_hit = valid_ff[idx] && (cmd_ff.now > time_ff[idx]) && (age > timeout);

   // oldest-entry scan compare, best so far kept in tgt_ff
   assign older = time_ff[idx] < time_ff[tgt_ff];

   // parallel key match and lowest free slot
   always_comb begin
      hit_any  = 1'b0;
      free_any = 1'b0;
      hit_idx  = '0;
      free_idx = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         match[i] = valid_ff[i] && (node_ff[i] == cmd_ff.node_id);
         if (match[i]) begin
            hit_any = 1'b1;
            hit_idx = IDX_W'(i);
         end
         if (!valid_ff[i]) begin
            free_any = 1'b1;
            free_idx = IDX_W'(i);
         end
      end
   end

   // entry read for the reported record
   always_comb begin
      unique case (state_ff)
         S_EXPIRE: rd_idx = idx;
         S_LOOKUP: rd_idx = hit_idx;
         default:  rd_idx = tgt_ff;
      endcase
   end

   // command sequencer
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      tgt_in       = tgt_ff;
      cmd_in       = cmd_ff;
      valid_in     = valid_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      q_pop        = 1'b0;
      emit         = 1'b0;
      wr_all       = 1'b0;
      wr_time      = 1'b0;
      wr_room      = 1'b0;
      wr_idx       = tgt_ff;

      // default record is the entry being read
      rsp_in.slot        = slot_of(rd_idx);
      rsp_in.node_out    = node_ff[rd_idx];
      rsp_in.room_out    = room_ff[rd_idx];
      rsp_in.flags_out   = flags_ff[rd_idx];
      rsp_in.last_of_run = 1'b1;

      unique case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop  = 1'b1;
               cmd_in = q_head;
               cnt_in = '0;
               if (q_head.kind == KIND_ACCESS) begin
                  state_in = S_EXPIRE;
               end else begin
                  state_in = S_LOOKUP;
               end
            end
         end

         // one slot a cycle, stall only when a record cannot leave
         S_EXPIRE: begin
            if (!expire_hit || out_free) begin
               if (expire_hit) begin
                  emit               = 1'b1;
                  rsp_in.event_res   = EV_EXPIRED;
                  rsp_in.last_of_run = 1'b0;
                  valid_in[idx]      = 1'b0;
               end
               cnt_in = cnt_ff + (IDX_W+1)'(1);
               if (cnt_ff == LAST_IDX) begin
                  state_in = S_LOOKUP;
               end
            end
         end

         S_LOOKUP: begin
            if (out_free) begin
               state_in = S_IDLE;
               priority if (cmd_ff.kind == KIND_ACCESS && hit_any) begin
                  emit             = 1'b1;
                  rsp_in.event_res = EV_FOUND;
                  wr_time          = 1'b1;
                  wr_idx           = hit_idx;
               end else if (cmd_ff.kind == KIND_ACCESS && free_any) begin
                  tgt_in   = free_idx;
                  state_in = S_CREATE;
               end else if (cmd_ff.kind == KIND_ACCESS) begin
                  tgt_in   = '0;
                  cnt_in   = (IDX_W+1)'(1);
                  state_in = S_MIN;
               end else if (cmd_ff.kind == KIND_SET_ROOM && hit_any) begin
                  emit             = 1'b1;
                  rsp_in.event_res = EV_FOUND;
                  rsp_in.room_out  = cmd_ff.room;
                  wr_room          = 1'b1;
                  wr_idx           = hit_idx;
               end else if (cmd_ff.kind == KIND_QUIT && hit_any) begin
                  emit              = 1'b1;
                  rsp_in.event_res  = EV_QUIT;
                  valid_in[hit_idx] = 1'b0;
               end else begin
                  emit             = 1'b1;
                  rsp_in.event_res = EV_NOT_FOUND;
                  rsp_in.slot      = '0;
                  rsp_in.node_out  = cmd_ff.node_id;
                  rsp_in.room_out  = '0;
                  rsp_in.flags_out = '0;
               end
            end
         end

         // strictly smaller time wins, so the lowest index keeps ties
         S_MIN: begin
            if (older) begin
               tgt_in = idx;
            end
            cnt_in = cnt_ff + (IDX_W+1)'(1);
            if (cnt_ff == LAST_IDX) begin
               state_in = S_EVICT;
            end
         end

         S_EVICT: begin
            if (out_free) begin
               emit               = 1'b1;
               rsp_in.event_res   = EV_EVICTED;
               rsp_in.last_of_run = 1'b0;
               state_in           = S_CREATE;
            end
         end

         S_CREATE: begin
            if (out_free) begin
               emit             = 1'b1;
               rsp_in.event_res = EV_CREATED;
               rsp_in.node_out  = cmd_ff.node_id;
               rsp_in.room_out  = cmd_ff.room;
               rsp_in.flags_out = cmd_ff.flags_in;
               wr_all           = 1'b1;
               valid_in[tgt_ff] = 1'b1;
               state_in         = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase

      if (emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   // state and output register, the record only loads when a new one leaves
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         tgt_ff       <= tgt_in;
         cmd_ff       <= cmd_in;
         if (emit) begin
            rsp_ff <= rsp_in;
         end
      end
   end

   // table entry writes
   always_ff @(posedge clock) begin
      if (wr_all) begin
         node_ff[wr_idx]  <= cmd_ff.node_id;
         room_ff[wr_idx]  <= cmd_ff.room;
         flags_ff[wr_idx] <= cmd_ff.flags_in;
         time_ff[wr_idx]  <= cmd_ff.now;
      end
      if (wr_time) begin
         time_ff[wr_idx] <= cmd_ff.now;
      end
      if (wr_room) begin
         room_ff[wr_idx] <= cmd_ff.room;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   // final record of a command always returns the sequencer to idle
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (emit && rsp_in.last_of_run) |=> (state_ff == S_IDLE))
      else $error("final record did not end the command");

   // eviction only happens on a full table
   a_evict_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EVICT) |-> (&valid_ff))
      else $error("eviction with a free slot");

   // oldest-entry scan stays within the table
   a_min_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MIN) |-> ((cnt_ff != '0) && (cnt_ff <= LAST_IDX)))
      else $error("oldest-entry scan out of range");

   // a created entry is valid afterwards
   a_create_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CREATE && out_free) |=> valid_ff[$past(tgt_ff)])
      else $error("created entry not marked valid");

endmodule

@@ src/session_table_timeout_evict.sv @@
// ----------------------------------------------------------------------------
// session_table_timeout_evict
// Fully associative session table with idle expiry and oldest-entry eviction.
// ----------------------------------------------------------------------------
// A queued front takes up to two request items while the engine works, so
// req_tready only drops when two commands are waiting. The engine runs one
// command at a time. An access scans every slot for expiry at one slot a
// cycle, stalling only while an expired record cannot leave; on a full
// table a second one-slot-a-cycle scan finds the oldest entry. Each result
// item leaves through an output register, and the engine holds while a new
// record cannot leave on a stalled rsp_tready. The user must write the idle
// timeout through the csr_ port only while the block is idle; the block
// itself does not enforce this.
module session_table_timeout_evict #(
   parameter int SLOTS = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   // configuration write
   input  logic                                csr_valid,
   output logic                                csr_ready,
   // idle_timeout[31:0]
   input  logic [stte_pkg::TIME_W-1:0]         csr_data,
   // request items
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // node_id[31:0], room[47:32], flags_in[55:48], now[87:56]
   input  logic [stte_pkg::REQ_DATA_W-1:0]     req_tdata,
   // opcode[1:0]
   input  logic [stte_pkg::OP_W-1:0]           req_tuser,
   // result items
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // slot[2:0], node_out[34:3], room_out[50:35], flags_out[58:51], zero above
   output logic [stte_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // event_res[2:0]
   output logic [stte_pkg::EVENT_W-1:0]        rsp_tuser,
   // last_of_run
   output logic                                rsp_tlast
);
   import stte_pkg::*;

   localparam int PAD_W = RSP_DATA_W - RSP_BITS;

   logic [TIME_W-1:0]  timeout_ff, timeout_in;
   logic               q_valid;
   logic               q_pop;
   cmd_type            q_head;
   rsp_type            rsp_item;

   // timeout register
   assign csr_ready  = 1'b1;
   assign timeout_in = (csr_valid && csr_ready) ? csr_data : timeout_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_RESET;
      end else begin
         timeout_ff <= timeout_in;
      end
   end

   stte_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_valid    (q_valid),
      .q_pop      (q_pop),
      .q_head     (q_head)
   );

   stte_engine #(
      .SLOTS (SLOTS)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .timeout   (timeout_ff),
      .q_valid   (q_valid),
      .q_pop     (q_pop),
      .q_head    (q_head),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_item  (rsp_item)
   );

   // pack the result item
   assign rsp_tdata = {{PAD_W{1'b0}}, rsp_item.flags_out, rsp_item.room_out,
                       rsp_item.node_out, rsp_item.slot};
   assign rsp_tuser = rsp_item.event_res;
   assign rsp_tlast = rsp_item.last_of_run;

endmodule

@@ sim/session_table_timeout_evict_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// session_table_timeout_evict_tb
// Drives request items into the session table and checks every result item
// against an in-bench copy of the table. A short table of directed requests
// opens the run, then random traffic over a small node pool under several
// idle timeouts, with random gaps and stalls on both streams.
// ----------------------------------------------------------------------------
module session_table_timeout_evict_tb;
   import stte_pkg::*;

   localparam int     SLOTS           = 8;
   localparam int     HALF_PERIOD     = 2;
   localparam int     RESET_CYCLES    = 11;
   localparam int     SETTLE_CYCLES   = 2 * SLOTS + 6;
   localparam int     LONG_HOLD       = 200;
   localparam int     PHASE_ITEMS     = 40;
   localparam int     POOL_SIZE       = 10;
   localparam int     MAX_REPORTS     = 10;
   localparam int     DIRECTED_COUNT  = 21;
   localparam longint CYCLE_LIMIT     = 400000;

   // dut ports, all driven to known values from time zero
   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [TIME_W-1:0]     csr_data   = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [OP_W-1:0]       req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [EVENT_W-1:0]    rsp_tuser;
   logic                  rsp_tlast;

   // directed request with an optional hand-written final result
   typedef struct packed {
      logic [OP_W-1:0]    op;
      logic [NODE_W-1:0]  node_id;
      logic [ROOM_W-1:0]  room;
      logic [FLAGS_W-1:0] flags_in;
      logic [TIME_W-1:0]  now;
      logic               typed;
      event_type          exp_event;
      logic [SLOT_W-1:0]  exp_slot;
      logic [ROOM_W-1:0]  exp_room;
      logic [FLAGS_W-1:0] exp_flags;
   } directed_row_type;

   // table starts empty with the reset timeout of 3600
   directed_row_type directed_rows [DIRECTED_COUNT] = '{
      // misses on an empty table, unused opcode with all ones
      '{OP_SET_ROOM, 32'h1234_5678, 16'hABCD, 8'h5A, 32'd0, 1'b1,
        EV_NOT_FOUND, 3'd0, 16'h0000, 8'h00},
      '{OP_QUIT, 32'h0000_0000, 16'h0000, 8'h00, 32'd0, 1'b1,
        EV_NOT_FOUND, 3'd0, 16'h0000, 8'h00},
      '{OP_UNUSED, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 1'b1,
        EV_NOT_FOUND, 3'd0, 16'h0000, 8'h00},
      // creates into the lowest free slots, zero and all-ones content
      '{OP_ACCESS, 32'h0000_0000, 16'h0000, 8'h00, 32'd0, 1'b1,
        EV_CREATED, 3'd0, 16'h0000, 8'h00},
      '{OP_ACCESS, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF, 32'd100, 1'b1,
        EV_CREATED, 3'd1, 16'hFFFF, 8'hFF},
      // hit refresh, set room hit, quit hit
      '{OP_ACCESS, 32'h0000_0000, 16'h1111, 8'h11, 32'd200, 1'b0,
        EV_FOUND, 3'd0, 16'h0000, 8'h00},
      '{OP_SET_ROOM, 32'hFFFF_FFFF, 16'h1234, 8'h00, 32'd0, 1'b0,
        EV_FOUND, 3'd0, 16'h0000, 8'h00},
      '{OP_QUIT, 32'h0000_0000, 16'h0000, 8'h00, 32'd0, 1'b0,
        EV_FOUND, 3'd0, 16'h0000, 8'h00},
      // fill the table
      '{OP_ACCESS, 32'hA5A5_0000, 16'h0100, 8'h10, 32'd300, 1'b0,
        EV_FOUND, 3'd0, 16'h0000, 8'h00},
      '{OP_ACCESS, 32'hA5A5_0001, 16'h0101, 8'h11, 32'd301, 1'b0,
        EV_FOUND, 3'd0, 16'h0000, 8'h00},
      '{OP_ACCESS, 32'hA5A5_0002, 16'h0102, 8'h12, 32'd302, 1'b0,
        EV_FOUND, 3'd0, 16'h0000, 8'h00},
      '{OP_ACCESS, 32'hA5A5_0003, 16'h0103, 8'h13, 32'd303, 1'b0,
        EV_FOUND, 3'd0, 16'h0000, 8'h00},
      '{OP_ACCESS, 32'hA5A5_0004, 16'h0104, 8'h14, 32'd304, 1'b0,
        EV_FOUND, 3'd0, 16'h0000, 8'h00},
      '{OP_ACCESS, 32'hA5A5_0005, 16'h0105, 8'h15, 32'd305, 1'b0,
        EV_FOUND, 3'd0, 16'h0000, 8'h00},
      '{OP_ACCESS, 32'hA5A5_0006, 16'h0106, 8'h16, 32'd306, 1'b0,
        EV_FOUND, 3'd0, 16'h0000, 8'h00},
      // full table: evict the oldest, then the evicted node misses
      '{OP_ACCESS, 32'h5A5A_5A5A, 16'h7777, 8'h77, 32'd400, 1'b0,
        EV_FOUND, 3'd0, 16'h0000, 8'h00},
      '{OP_SET_ROOM, 32'hFFFF_FFFF, 16'h2222, 8'h00, 32'd0, 1'b1,
        EV_NOT_FOUND, 3'd0, 16'h0000, 8'h00},
      // time going backwards expires nothing
      '{OP_ACCESS, 32'hC0DE_0001, 16'h3333, 8'h33, 32'd5, 1'b0,
        EV_FOUND, 3'd0, 16'h0000, 8'h00},
      // idle time equal to the timeout survives, one past it expires
      '{OP_ACCESS, 32'h0BAD_0001, 16'h4444, 8'h44, 32'd3906, 1'b0,
        EV_FOUND, 3'd0, 16'h0000, 8'h00},
      // maximum time expires the addressed node itself before lookup
      '{OP_ACCESS, 32'h0BAD_0001, 16'h5555, 8'h55, 32'hFFFF_FFFF, 1'b0,
        EV_FOUND, 3'd0, 16'h0000, 8'h00},
      '{OP_ACCESS, 32'h8000_0000, 16'h8000, 8'h80, 32'd0, 1'b0,
        EV_FOUND, 3'd0, 16'h0000, 8'h00}
   };

   // session table mirror
   logic               sess_valid [SLOTS];
   logic [NODE_W-1:0]  sess_node  [SLOTS];
   logic [ROOM_W-1:0]  sess_room  [SLOTS];
   logic [FLAGS_W-1:0] sess_flags [SLOTS];
   logic [TIME_W-1:0]  sess_time  [SLOTS];
   logic [TIME_W-1:0]  idle_timeout_model = TIMEOUT_RESET;

   rsp_type            pending_results [$];
   logic [NODE_W-1:0]  node_pool [POOL_SIZE];
   logic [TIME_W-1:0]  clock_now = '0;

   bit     req_no_gap    = 1'b0;
   bit     rsp_stall_off = 1'b0;
   bit     hold_rsp_long = 1'b0;
   int     mismatches    = 0;
   int     requests_sent = 0;
   int     results_seen  = 0;
   int     settings_used = 1;
   int     event_seen [6] = '{default: 0};
   longint cycle_count   = 0;

   session_table_timeout_evict #(
      .SLOTS (SLOTS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #HALF_PERIOD clock = ~clock;

   initial begin : table_clear
      for (int i = 0; i < SLOTS; i++) begin
         sess_valid[i] = 1'b0;
         sess_node[i]  = '0;
         sess_room[i]  = '0;
         sess_flags[i] = '0;
         sess_time[i]  = '0;
      end
   end

   // queue one expected result item
   function automatic void push_result(input event_type ev, input int idx,
                                       input logic [NODE_W-1:0] node_id,
                                       input logic [ROOM_W-1:0] room,
                                       input logic [FLAGS_W-1:0] flags,
                                       input logic last);
      rsp_type r;
      r.event_res   = ev;
      r.slot        = SLOT_W'(idx);
      r.node_out    = node_id;
      r.room_out    = room;
      r.flags_out   = flags;
      r.last_of_run = last;
      pending_results.push_back(r);
   endfunction

   function automatic void push_entry(input event_type ev, input int idx, input logic last);
      push_result(ev, idx, sess_node[idx], sess_room[idx], sess_flags[idx], last);
   endfunction

   function automatic int find_session(input logic [NODE_W-1:0] node_id);
      int i;
      for (i = 0; i < SLOTS; i++)
         if (sess_valid[i] && sess_node[i] == node_id)
            return i;
      return -1;
   endfunction

   // update the mirror for one request and queue the results it causes
   function automatic void predict_session(input logic [OP_W-1:0] op,
                                           input logic [NODE_W-1:0] node_id,
                                           input logic [ROOM_W-1:0] room,
                                           input logic [FLAGS_W-1:0] flags_in,
                                           input logic [TIME_W-1:0] now);
      int i;
      int hit;
      int spot;
      hit = -1;
      if (op == OP_ACCESS) begin
         // expiry sweep in slot order
         for (i = 0; i < SLOTS; i++)
            if (sess_valid[i] && now > sess_time[i]
                && (now - sess_time[i]) > idle_timeout_model) begin
               push_entry(EV_EXPIRED, i, 1'b0);
               sess_valid[i] = 1'b0;
            end
         hit = find_session(node_id);
         if (hit >= 0) begin
            sess_time[hit] = now;
            push_entry(EV_FOUND, hit, 1'b1);
         end else begin
            spot = -1;
            for (i = 0; i < SLOTS; i++)
               if (!sess_valid[i] && spot < 0)
                  spot = i;
            // full table: strictly oldest wins, lowest slot on ties
            if (spot < 0) begin
               spot = 0;
               for (i = 1; i < SLOTS; i++)
                  if (sess_time[i] < sess_time[spot])
                     spot = i;
               push_entry(EV_EVICTED, spot, 1'b0);
            end
            sess_valid[spot] = 1'b1;
            sess_node[spot]  = node_id;
            sess_room[spot]  = room;
            sess_flags[spot] = flags_in;
            sess_time[spot]  = now;
            push_entry(EV_CREATED, spot, 1'b1);
         end
      end else begin
         if (op != OP_UNUSED)
            hit = find_session(node_id);
         if (hit < 0) begin
            push_result(EV_NOT_FOUND, 0, node_id, '0, '0, 1'b1);
         end else if (op == OP_SET_ROOM) begin
            sess_room[hit] = room;
            push_entry(EV_FOUND, hit, 1'b1);
         end else begin
            push_entry(EV_QUIT, hit, 1'b1);
            sess_valid[hit] = 1'b0;
         end
      end
   endfunction

   // offer one request item and predict once it is taken
   task automatic offer_request(input logic [OP_W-1:0] op,
                                input logic [NODE_W-1:0] node_id,
                                input logic [ROOM_W-1:0] room,
                                input logic [FLAGS_W-1:0] flags_in,
                                input logic [TIME_W-1:0] now,
                                input bit use_fixed, input rsp_type fixed_rsp);
      int gap;
      int depth;
      gap = req_no_gap ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {now, flags_in, room, node_id};
      req_tuser  <= op;
      do @(posedge clock); while (!req_tready);
      depth = pending_results.size();
      predict_session(op, node_id, room, flags_in, now);
      // hand-written expectation replaces the predicted one
      if (use_fixed) begin
         while (pending_results.size() > depth)
            void'(pending_results.pop_back());
         pending_results.push_back(fixed_rsp);
      end
      requests_sent++;
   endtask

   // wait on the clock until every expected result is back, checked after each edge
   task automatic wait_drained();
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   // idle timeout write, only with the engine quiet
   task automatic write_timeout(input logic [TIME_W-1:0] value);
      req_tvalid <= 1'b0;
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      idle_timeout_model = value;
      settings_used++;
   endtask

   // random traffic over a small node pool so hits, evictions and expiry mix
   task automatic random_phase(input int count, input bit with_pressure);
      int k;
      int sel;
      int step;
      logic [OP_W-1:0]   op;
      logic [NODE_W-1:0] node_id;
      rsp_type           unused_rsp;
      unused_rsp = '0;
      for (k = 0; k < POOL_SIZE; k++)
         node_pool[k] = $urandom();
      for (k = 0; k < count; k++) begin
         if (k % 10 == 0) begin
            req_no_gap    = ($urandom_range(0, 3) == 0);
            rsp_stall_off = ($urandom_range(0, 3) == 0);
         end
         // back-pressure: receiver holds off while requests keep coming
         if (with_pressure && k == 5)
            hold_rsp_long = 1'b1;
         if (with_pressure && k >= 5 && k < 25)
            req_no_gap = 1'b1;
         // sender pause until the table has answered everything
         if (with_pressure && k == 30) begin
            req_tvalid <= 1'b0;
            wait_drained();
         end
         // time step: repeat, small, around the timeout, jump, or backwards
         step = $urandom_range(0, 9);
         case (step)
            0, 1: ;
            2, 3, 4, 5: clock_now = clock_now + TIME_W'($urandom_range(1, 20));
            6, 7: clock_now = clock_now + idle_timeout_model
                              + TIME_W'($urandom_range(0, 2)) - 32'd1;
            8: clock_now = $urandom();
            default: clock_now = clock_now - TIME_W'($urandom_range(0, 50));
         endcase
         sel     = $urandom_range(0, 19);
         node_id = node_pool[$urandom_range(0, POOL_SIZE - 1)];
         if (sel < 12) begin
            op = OP_ACCESS;
         end else if (sel < 15) begin
            op = OP_SET_ROOM;
         end else if (sel < 18) begin
            op = OP_QUIT;
         end else if (sel == 18) begin
            op = OP_UNUSED;
         end else begin
            op      = OP_ACCESS;
            node_id = $urandom();
         end
         offer_request(op, node_id, ROOM_W'($urandom()), FLAGS_W'($urandom()),
                       clock_now, 1'b0, unused_rsp);
      end
      req_no_gap = 1'b0;
   endtask

   // result side: random stalls, one long hold on request
   initial begin : rsp_side
      int stall;
      wait (!reset);
      forever begin
         if (hold_rsp_long) begin
            hold_rsp_long = 1'b0;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end
         stall = rsp_stall_off ? 0 : $urandom_range(0, 8);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
      end
   end

   // compare each accepted result with the oldest expectation
   always @(posedge clock) begin : result_check
      rsp_type seen;
      rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen.event_res   = event_type'(rsp_tuser);
         seen.slot        = rsp_tdata[2:0];
         seen.node_out    = rsp_tdata[34:3];
         seen.room_out    = rsp_tdata[50:35];
         seen.flags_out   = rsp_tdata[58:51];
         seen.last_of_run = rsp_tlast;
         results_seen++;
         if (rsp_tuser <= EV_NOT_FOUND)
            event_seen[rsp_tuser]++;
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("[%0t] result item with none expected: ev %0d slot %0d node %h",
                        $time, seen.event_res, seen.slot, seen.node_out);
         end else begin
            want = pending_results.pop_front();
            if (seen !== want) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS) begin
                  $display("[%0t] result %0d mismatch", $time, results_seen);
                  $display("   expected ev %0d slot %0d node %h room %h flags %h last %b",
                           want.event_res, want.slot, want.node_out, want.room_out,
                           want.flags_out, want.last_of_run);
                  $display("   actual   ev %0d slot %0d node %h room %h flags %h last %b",
                           seen.event_res, seen.slot, seen.node_out, seen.room_out,
                           seen.flags_out, seen.last_of_run);
               end
            end
         end
      end
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("session_table_timeout_evict verification failed");
      $finish;
   end

   initial begin : stimulus
      int row;
      rsp_type fixed_rsp;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table under the reset timeout
      for (row = 0; row < DIRECTED_COUNT; row++) begin
         fixed_rsp.event_res   = directed_rows[row].exp_event;
         fixed_rsp.slot        = directed_rows[row].exp_slot;
         fixed_rsp.node_out    = directed_rows[row].node_id;
         fixed_rsp.room_out    = directed_rows[row].exp_room;
         fixed_rsp.flags_out   = directed_rows[row].exp_flags;
         fixed_rsp.last_of_run = 1'b1;
         offer_request(directed_rows[row].op, directed_rows[row].node_id,
                       directed_rows[row].room, directed_rows[row].flags_in,
                       directed_rows[row].now, directed_rows[row].typed, fixed_rsp);
      end
      clock_now = 32'd4000;

      // timeout extremes, a tiny one with back-pressure, a random one, back to reset
      write_timeout(32'd0);
      random_phase(PHASE_ITEMS, 1'b0);
      write_timeout(32'hFFFF_FFFF);
      random_phase(PHASE_ITEMS, 1'b0);
      write_timeout(32'd5);
      random_phase(PHASE_ITEMS, 1'b1);
      write_timeout(TIME_W'($urandom_range(1, 5000)));
      random_phase(PHASE_ITEMS, 1'b0);
      write_timeout(TIMEOUT_RESET);
      random_phase(PHASE_ITEMS, 1'b0);

      req_tvalid <= 1'b0;
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_results.size() != 0)
         mismatches++;

      $display("%0d request items, %0d result items checked under %0d timeout settings",
               requests_sent, results_seen, settings_used);
      $display("results: expired %0d evicted %0d quit %0d found %0d created %0d missed %0d",
               event_seen[EV_EXPIRED], event_seen[EV_EVICTED], event_seen[EV_QUIT],
               event_seen[EV_FOUND], event_seen[EV_CREATED], event_seen[EV_NOT_FOUND]);
      if (mismatches == 0) begin
         $display("session_table_timeout_evict verification clean");
      end else begin
         $display("session_table_timeout_evict verification failed");
      end
      $finish;
   end

endmodule
